[hdl/pulse_beat_rate_detector_macros.svh]
// assertion macros shared by the detector
`ifndef PULSE_BEAT_RATE_DETECTOR_MACROS_SVH
`define PULSE_BEAT_RATE_DETECTOR_MACROS_SVH

// condition implies consequence in the same cycle
`define PBRD_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PBRD_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pbrd_pkg.sv]
package pbrd_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_BEAT   = 3'd0;
  localparam logic [2:0] CFG_MAX_BEAT   = 3'd1;
  localparam logic [2:0] CFG_TIMEOUT    = 3'd2;
  localparam logic [2:0] CFG_THR_FLOOR  = 3'd3;
  localparam logic [2:0] CFG_BASE_ALPHA = 3'd4;
  localparam logic [2:0] CFG_PEAK_DECAY = 3'd5;
  localparam logic [2:0] CFG_PEAK_GAIN  = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // register reset values
  localparam logic [15:0] MIN_BEAT_RST   = 16'd300;
  localparam logic [15:0] MAX_BEAT_RST   = 16'd2000;
  localparam logic [15:0] TIMEOUT_RST    = 16'd3000;
  localparam logic [17:0] THR_FLOOR_RST  = 18'd500;
  localparam logic [15:0] BASE_ALPHA_RST = 16'd62259;
  localparam logic [15:0] PEAK_DECAY_RST = 16'd64225;
  localparam logic [15:0] PEAK_GAIN_RST  = 16'd1311;

  // fixed point widths
  localparam int SAMPLE_W = 18;
  localparam int LEVEL_W  = 34;
  localparam int COEF_W   = 17;
  localparam int PROD_W   = LEVEL_W + COEF_W;
  localparam int NUM_W    = 24;
  localparam int DEN_W    = 16;

  // 60000 bpm-ms in Q16.8
  localparam logic [NUM_W-1:0] RATE_NUM = 24'd15360000;

  localparam int AVG_DEPTH_DEF   = 4;
  localparam int SAMPLE_BITS_DEF = 18;

endpackage

[hdl/pbrd_smul.sv]
module pbrd_smul #(
  parameter int AW = pbrd_pkg::LEVEL_W,
  parameter int BW = pbrd_pkg::COEF_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  import pbrd_pkg::*;

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_q;
  logic [AW-1:0] hi;
  logic [BW-1:0] lo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [AW:0]   sum;

  // one multiplier bit per cycle, product shifts in from the top
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, a_q} : {(AW + 1){1'b0}});
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_q  <= a;
        hi   <= '0;
        lo   <= b;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        hi  <= sum[AW:1];
        lo  <= {sum[0], lo[BW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/pbrd_sdiv.sv]
module pbrd_sdiv #(
  parameter int NW = pbrd_pkg::NUM_W,
  parameter int DW = pbrd_pkg::DEN_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  import pbrd_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] den_q;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_q <= den;
        rem   <= '0;
        quo   <= num;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
        quo <= {quo[NW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/pulse_beat_rate_detector.sv]
// Pulse beat and rate detector for one infrared photodiode channel.
// Input channel: in_valid/in_stall carry ir_sample and now_ms; one item is
// accepted when in_valid is high and in_stall low. Output channel:
// out_valid/out_stall carry heart_rate_q8, beat_seen, beat_counted, ac_level
// and thr_level, exactly one result item per input item.
// Configuration: cfg_write with cfg_index and cfg_data writes one register in
// a cycle; write only while no item is in flight.
// Sequence: baseline and peak products run on two bit-serial multipliers
// side by side, and each product is used once both multipliers are done; the
// first sample after reset skips the baseline product. A counted beat adds
// two bit-serial divider passes, a summing step per valid ring entry and a
// step to start the mean.
// One item is in flight at a time; in_stall is high from accept until the
// result is loaded into the output register, and the next item is taken
// while that result waits.
// When the receiver stalls, the finished result holds in the output register
// and a following item finishes its work but waits before loading.
// Reset (rst, synchronous) restores register defaults, clears baseline, peak,
// beat history and rate; ring entries are not cleared.
module pulse_beat_rate_detector #(
  parameter int AVG_DEPTH   = pbrd_pkg::AVG_DEPTH_DEF,
  parameter int SAMPLE_BITS = pbrd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pbrd_pkg::SAMPLE_W-1:0]      ir_sample,
  input  logic [31:0]                        now_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [15:0]                        heart_rate_q8,
  output logic                               beat_seen,
  output logic                               beat_counted,
  output logic signed [pbrd_pkg::SAMPLE_W:0] ac_level,
  output logic [pbrd_pkg::SAMPLE_W-1:0]      thr_level,
  input  logic                               cfg_write,
  input  logic [pbrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pbrd_pkg::*;
  `include "pulse_beat_rate_detector_macros.svh"

  localparam int FW = $clog2(AVG_DEPTH + 1);
  localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SW = DEN_W + FW;
  localparam logic [SAMPLE_W-1:0] SMASK =
    (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_AC, S_MUL2, S_DECIDE, S_DIV1, S_SUM, S_DIV2, S_TMO, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0]         min_beat, max_beat, tmo;
  logic [SAMPLE_W-1:0] thr_floor;
  logic [15:0]         alpha, decay, gain;

  // detector state
  logic [LEVEL_W-1:0]  base, peak;
  logic                seeded, above_flag, last_valid;
  logic [31:0]         last_time;
  logic [15:0]         ring [AVG_DEPTH];
  logic [PW-1:0]       pos;
  logic [FW-1:0]       fill, idx;
  logic [SW-1:0]       sum;
  logic [15:0]         reported;

  // per item working registers
  logic [SAMPLE_W-1:0] sample_r;
  logic [31:0]         now_r;
  logic [SAMPLE_W:0]   ac_r;
  logic [SAMPLE_W-1:0] thr_r;
  logic                seen_r, counted_r;

  // serial unit handshakes
  logic               mul_start, mx_done, my_done;
  logic [LEVEL_W-1:0] mx_a, my_a;
  logic [COEF_W-1:0]  mx_b, my_b;
  logic [PROD_W-1:0]  mx_p, my_p;
  logic               div_start, dv_done;
  logic [NUM_W-1:0]   dv_num, dv_quo;
  logic [DEN_W-1:0]   dv_den;

  pbrd_smul #(.AW(LEVEL_W), .BW(COEF_W)) u_mul_x (
    .clk(clk), .rst(rst), .start(mul_start), .a(mx_a), .b(mx_b),
    .done(mx_done), .prod(mx_p)
  );

  pbrd_smul #(.AW(LEVEL_W), .BW(COEF_W)) u_mul_y (
    .clk(clk), .rst(rst), .start(mul_start), .a(my_a), .b(my_b),
    .done(my_done), .prod(my_p)
  );

  pbrd_sdiv #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  // combinational helpers
  logic [SAMPLE_W-1:0] sample_in;
  logic [SAMPLE_W:0]   ac_c;
  logic [SAMPLE_W-1:0] mag_c;
  logic [LEVEL_W-1:0]  decayed_c, fed_c, peak_c;
  logic [SAMPLE_W-1:0] thr_c;
  logic                above_c;
  logic [31:0]         interval_c, elapsed_c;
  logic [15:0]         rate_c;
  logic [PW-1:0]       pos_next;

  assign sample_in  = ir_sample & SMASK;
  assign ac_c       = {1'b0, sample_r} - {1'b0, base[LEVEL_W-1:16]};
  assign mag_c      = ac_c[SAMPLE_W] ? SAMPLE_W'(-ac_c) : ac_c[SAMPLE_W-1:0];
  assign decayed_c  = mx_p[LEVEL_W+15:16];
  assign fed_c      = my_p[LEVEL_W-1:0];
  assign peak_c     = (decayed_c > fed_c) ? decayed_c : fed_c;
  assign thr_c      = ({1'b0, peak_c[LEVEL_W-1:17]} < thr_floor) ?
                      thr_floor : {1'b0, peak_c[LEVEL_W-1:17]};
  assign above_c    = $signed({ac_r[SAMPLE_W], ac_r}) > $signed({2'b00, thr_r});
  assign interval_c = now_r - last_time;
  assign elapsed_c  = now_r - last_time;
  assign rate_c     = (dv_quo > NUM_W'(16'hFFFF)) ? 16'hFFFF : dv_quo[15:0];
  assign pos_next   = (pos == PW'(AVG_DEPTH - 1)) ? '0 : PW'(pos + 1'b1);
  assign in_stall   = (state != S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_beat  <= MIN_BEAT_RST;
      max_beat  <= MAX_BEAT_RST;
      tmo       <= TIMEOUT_RST;
      thr_floor <= THR_FLOOR_RST;
      alpha     <= BASE_ALPHA_RST;
      decay     <= PEAK_DECAY_RST;
      gain      <= PEAK_GAIN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIN_BEAT:   min_beat  <= cfg_data[15:0];
        CFG_MAX_BEAT:   max_beat  <= cfg_data[15:0];
        CFG_TIMEOUT:    tmo       <= cfg_data[15:0];
        CFG_THR_FLOOR:  thr_floor <= cfg_data[SAMPLE_W-1:0];
        CFG_BASE_ALPHA: alpha     <= cfg_data[15:0];
        CFG_PEAK_DECAY: decay     <= cfg_data[15:0];
        CFG_PEAK_GAIN:  gain      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base       <= '0;
      peak       <= '0;
      seeded     <= 1'b0;
      above_flag <= 1'b0;
      last_time  <= '0;
      last_valid <= 1'b0;
      pos        <= '0;
      fill       <= '0;
      reported   <= '0;
      mul_start  <= 1'b0;
      div_start  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= sample_in;
            now_r    <= now_ms;
            if (!seeded) begin
              base   <= {sample_in, 16'd0};
              seeded <= 1'b1;
              state  <= S_AC;
            end else begin
              mx_a      <= base;
              mx_b      <= {1'b0, alpha};
              my_a      <= LEVEL_W'(sample_in);
              my_b      <= COEF_W'(17'h10000 - {1'b0, alpha});
              mul_start <= 1'b1;
              state     <= S_MUL1;
            end
          end
        end
        // baseline blend
        S_MUL1: begin
          if (mx_done && my_done) begin
            base  <= LEVEL_W'(mx_p[LEVEL_W+15:16] + my_p[LEVEL_W-1:0]);
            state <= S_AC;
          end
        end
        S_AC: begin
          ac_r      <= ac_c;
          mx_a      <= peak;
          mx_b      <= {1'b0, decay};
          my_a      <= LEVEL_W'(mag_c);
          my_b      <= {1'b0, gain};
          mul_start <= 1'b1;
          state     <= S_MUL2;
        end
        // peak tracker and threshold
        S_MUL2: begin
          if (mx_done && my_done) begin
            peak  <= peak_c;
            thr_r <= thr_c;
            state <= S_DECIDE;
          end
        end
        // rising crossing check
        S_DECIDE: begin
          above_flag <= above_c;
          seen_r     <= above_c && !above_flag;
          counted_r  <= 1'b0;
          state      <= S_TMO;
          if (above_c && !above_flag) begin
            last_time  <= now_r;
            last_valid <= 1'b1;
            if (last_valid && interval_c > {16'd0, min_beat} &&
                interval_c < {16'd0, max_beat}) begin
              dv_num    <= RATE_NUM;
              dv_den    <= interval_c[DEN_W-1:0];
              div_start <= 1'b1;
              state     <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (dv_done) begin
            ring[pos] <= rate_c;
            pos       <= pos_next;
            if (fill < FW'(AVG_DEPTH)) begin
              fill <= fill + 1'b1;
            end
            sum       <= '0;
            idx       <= '0;
            counted_r <= 1'b1;
            state     <= S_SUM;
          end
        end
        // sum the valid ring entries one per cycle
        S_SUM: begin
          if (idx < fill) begin
            sum <= sum + SW'(ring[idx[PW-1:0]]);
            idx <= idx + 1'b1;
          end else begin
            dv_num    <= NUM_W'(sum);
            dv_den    <= DEN_W'(fill);
            div_start <= 1'b1;
            state     <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (dv_done) begin
            reported <= dv_quo[15:0];
            state    <= S_TMO;
          end
        end
        // silence clears beat history and the reported rate
        S_TMO: begin
          if (last_valid && elapsed_c > {16'd0, tmo}) begin
            last_valid <= 1'b0;
            last_time  <= '0;
            fill       <= '0;
            pos        <= '0;
            reported   <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            heart_rate_q8 <= reported;
            beat_seen     <= seen_r;
            beat_counted  <= counted_r;
            ac_level      <= ac_r;
            thr_level     <= thr_r;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `PBRD_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "item overlap")
  `PBRD_ASSERT_NOW(a_counted_is_seen, out_valid && beat_counted, beat_seen, "count w/o beat")
  `PBRD_ASSERT_NOW(a_empty_rate_zero, fill == '0, reported == '0, "rate without history")
  `PBRD_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FW'(AVG_DEPTH), "ring overfilled")

endmodule
